[rtl/deque_with_delete_all_core_macros.svh]
// assertion helpers used by the checker file
`ifndef DEQUE_WITH_DELETE_ALL_CORE_MACROS_SVH
`define DEQUE_WITH_DELETE_ALL_CORE_MACROS_SVH

// clocked assertion, quiet while reset is held
`define DQDA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// clocked assertion that also holds across reset
`define DQDA_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/dqda_pkg.sv]
package dqda_pkg;

    typedef enum logic [2:0] {
        OP_APPEND  = 3'd0,
        OP_PREPEND = 3'd1,
        OP_DEL_FST = 3'd2,
        OP_DEL_LST = 3'd3,
        OP_DEL_ALL = 3'd4,
        OP_READ    = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DEL
    } t_state;

    // memory port strobes
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

[rtl/deque_with_delete_all_core.sv]
// append, prepend, delete first/last, out-of-range read and unused op codes load
//   the result register at the accepting edge; a read in range loads it from S_READ
// delete all walks the stored entries on the one read port and loads it once the walk ends
// throughput: one request in flight, the next taken once the result register is free or
//   draining: one per cycle for push and pop, none while a read or delete all is busy
// reset (synchronous, active low) clears head, count and result valid, not the entry memory
module deque_with_delete_all_core #(
    parameter int DEPTH = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [2:0]          i_op,
    input  logic signed [31:0]  i_value,
    input  logic [7:0]          i_position,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [31:0]  o_read_data,
    output logic [8:0]          o_count,
    output logic [1:0]          o_status
);

    import dqda_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // physical index width
    localparam int CW = $clog2(DEPTH + 1);                // entry count width
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    // control state
    t_state             r_state, n_state;
    logic [PW-1:0]      r_head, n_head;
    logic [CW-1:0]      r_count, n_count;

    // delete-all walk
    logic [CW-1:0]      r_rd_idx, n_rd_idx;   // next entry to fetch
    logic [CW-1:0]      r_wr_idx, n_wr_idx;   // next survivor slot
    logic               r_pend, n_pend;       // memory data arriving this cycle
    logic signed [31:0] r_del_val, n_del_val;

    // result register
    logic               r_out_valid, n_out_valid;
    logic signed [31:0] r_out_data, n_out_data;
    logic [8:0]         r_out_count, n_out_count;
    t_status            r_out_status, n_out_status;

    // memory port
    t_mem_ctl           mem_ctl;
    logic [PW-1:0]      mem_waddr, mem_raddr;
    logic signed [31:0] mem_wdata, mem_rdata;

    logic               accept;
    logic               load_out;

    // physical index of a logical offset from the head; offset stays below DEPTH
    function automatic logic [PW-1:0] slot(input logic [PW-1:0] head,
                                           input logic [PW-1:0] offset);
        logic [PW:0] sum;
        sum = {1'b0, head} + {1'b0, offset};
        if (sum >= (PW+1)'(DEPTH)) begin
            sum = sum - (PW+1)'(DEPTH);
        end
        return sum[PW-1:0];
    endfunction

    dqda_ram #(
        .DEPTH (DEPTH),
        .AW    (PW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // take a request only when idle and the result register is free or draining
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_count      = r_count;
        n_rd_idx     = r_rd_idx;
        n_wr_idx     = r_wr_idx;
        n_pend       = r_pend;
        n_del_val    = r_del_val;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        mem_ctl      = '0;
        mem_waddr    = '0;
        mem_wdata    = i_value;
        mem_raddr    = '0;
        load_out     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_out_status = ST_OK;
                    unique case (i_op)
                        OP_APPEND: begin
                            load_out = 1'b1;
                            if (r_count == FULL_CNT) begin
                                n_out_status = ST_FULL;
                            end else begin
                                // tail slot sits count entries past the head
                                mem_ctl.wr_en = 1'b1;
                                mem_waddr     = slot(r_head, PW'(r_count));
                                n_count       = r_count + 1'b1;
                            end
                        end
                        OP_PREPEND: begin
                            load_out = 1'b1;
                            if (r_count == FULL_CNT) begin
                                n_out_status = ST_FULL;
                            end else begin
                                // head steps back one slot, wrapping
                                n_head        = (r_head == '0) ? PW'(DEPTH - 1) : r_head - 1'b1;
                                mem_ctl.wr_en = 1'b1;
                                mem_waddr     = n_head;
                                n_count       = r_count + 1'b1;
                            end
                        end
                        OP_DEL_FST: begin
                            load_out = 1'b1;
                            if (r_count == '0) begin
                                n_out_status = ST_EMPTY;
                            end else begin
                                n_head  = slot(r_head, PW'(1));
                                n_count = r_count - 1'b1;
                            end
                        end
                        OP_DEL_LST: begin
                            load_out = 1'b1;
                            if (r_count == '0) begin
                                n_out_status = ST_EMPTY;
                            end else begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        OP_DEL_ALL: begin
                            // start the compaction walk from the head
                            n_del_val = i_value;
                            n_rd_idx  = '0;
                            n_wr_idx  = '0;
                            n_pend    = 1'b0;
                            n_state   = S_DEL;
                        end
                        OP_READ: begin
                            if (32'(i_position) < 32'(r_count)) begin
                                mem_ctl.rd_en = 1'b1;
                                mem_raddr     = slot(r_head, PW'(i_position));
                                n_state       = S_READ;
                            end else begin
                                load_out     = 1'b1;
                                n_out_status = ST_RANGE;
                            end
                        end
                        default: begin
                            // unused op codes leave everything alone
                            load_out = 1'b1;
                        end
                    endcase
                end
            end

            S_READ: begin
                load_out     = 1'b1;
                n_out_data   = mem_rdata;
                n_out_status = ST_OK;
                n_state      = S_IDLE;
            end

            S_DEL: begin
                // fetch stage: one entry per cycle, reads always run ahead of writes
                if (r_rd_idx != r_count) begin
                    mem_ctl.rd_en = 1'b1;
                    mem_raddr     = slot(r_head, PW'(r_rd_idx));
                    n_rd_idx      = r_rd_idx + 1'b1;
                    n_pend        = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end

                // compare stage: survivors are written back in order
                if (r_pend && (mem_rdata != r_del_val)) begin
                    mem_ctl.wr_en = 1'b1;
                    mem_waddr     = slot(r_head, PW'(r_wr_idx));
                    mem_wdata     = mem_rdata;
                    n_wr_idx      = r_wr_idx + 1'b1;
                end

                // walk done once the last fetched word has been compared
                if ((r_rd_idx == r_count) && !r_pend) begin
                    n_count      = r_wr_idx;
                    load_out     = 1'b1;
                    n_out_status = ST_OK;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (load_out) begin
            n_out_valid = 1'b1;
            if (r_state != S_READ) begin
                n_out_data = '0;
            end
        end
        n_out_count = 9'(n_count);
        if (!load_out) begin
            n_out_count = r_out_count;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_idx     <= n_rd_idx;
        r_wr_idx     <= n_wr_idx;
        r_del_val    <= n_del_val;
        r_out_data   <= n_out_data;
        r_out_count  <= n_out_count;
        r_out_status <= n_out_status;
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;
    assign o_count     = r_out_count;
    assign o_status    = r_out_status;

endmodule

[rtl/dqda_ram.sv]
module dqda_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                i_clk,
    input  dqda_pkg::t_mem_ctl  i_ctl,
    input  logic [AW-1:0]       i_waddr,
    input  logic signed [31:0]  i_wdata,
    input  logic [AW-1:0]       i_raddr,
    output logic signed [31:0]  o_rdata
);

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/dqda_checker.sv]
`include "deque_with_delete_all_core_macros.svh"

module dqda_checker #(
    parameter int DEPTH = 256
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic signed [31:0]  o_read_data,
    input logic [8:0]          o_count,
    input logic [1:0]          o_status
);

    import dqda_pkg::*;

    localparam logic [8:0] DEPTH_CNT = 9'(DEPTH);

    // a stalled result keeps its valid and its count
    `DQDA_ASSERT(a_out_hold, (o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_count) && $stable(o_status)), "result changed while stalled")

    // only a good read carries data
    `DQDA_ASSERT(a_data_zero, (o_out_valid && o_status != ST_OK |-> o_read_data == 32'sd0), "read data set on a failed request")

    // full is only reported with a full list
    `DQDA_ASSERT(a_full_cnt, (o_out_valid && o_status == ST_FULL |-> o_count == DEPTH_CNT), "full status with spare room")

    // empty is only reported with no entries
    `DQDA_ASSERT(a_empty_cnt, (o_out_valid && o_status == ST_EMPTY |-> o_count == 9'd0), "empty status with entries left")

    // no result right after reset
    `DQDA_ASSERT_RST(a_rst_idle, (!i_rst_n |=> !o_out_valid), "result valid after reset")

endmodule

bind deque_with_delete_all_core dqda_checker #(.DEPTH(DEPTH)) u_dqda_checker (.*);

[verif/deque_with_delete_all_core_test.sv]
`timescale 1ns / 100ps

module deque_with_delete_all_core_test;
    import dqda_pkg::*;

    localparam int DEPTH       = 256;
    localparam int STUCK_LIMIT = 4000;

    // op codes the block ignores
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    typedef struct {
        logic [2:0]         op;
        logic signed [31:0] word;
        logic [7:0]         pos;
    } t_request;

    typedef struct {
        logic signed [31:0] read_data;
        logic [8:0]         count;
        t_status            status;
    } t_reply;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    logic [2:0]         i_op        = OP_APPEND;
    logic signed [31:0] i_value     = '0;
    logic [7:0]         i_position  = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [31:0] o_read_data;
    logic [8:0]         o_count;
    logic [1:0]         o_status;

    deque_with_delete_all_core #(
        .DEPTH(DEPTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_op       (i_op),
        .i_value    (i_value),
        .i_position (i_position),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_read_data(o_read_data),
        .o_count    (o_count),
        .o_status   (o_status)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // requests waiting to be driven, replies owed by the block
    t_request request_q[$];
    t_reply   reply_q[$];
    int       fail_count = 0;
    bit       no_idle    = 1'b0;

    // shadow copy of the ring buffer
    logic signed [31:0] dq_mem [DEPTH];
    logic [7:0]         dq_head  = '0;
    logic [8:0]         dq_count = '0;

    // small set of recurring words so delete all finds matches
    logic signed [31:0] word_pool [8];

    function automatic logic [7:0] ring_slot(input logic [7:0] offset);
        return dq_head + offset;
    endfunction

    // apply one accepted request to the shadow deque, queue the reply it owes
    task automatic apply_deque_op(input logic [2:0] op, input logic signed [31:0] word,
                                  input logic [7:0] pos);
        t_reply             rep;
        logic [8:0]         kept;
        logic signed [31:0] e;
        rep.read_data = '0;
        rep.status    = ST_OK;
        case (op)
            OP_APPEND: begin
                if (dq_count == DEPTH) begin
                    rep.status = ST_FULL;
                end else begin
                    dq_mem[ring_slot(dq_count[7:0])] = word;
                    dq_count++;
                end
            end
            OP_PREPEND: begin
                if (dq_count == DEPTH) begin
                    rep.status = ST_FULL;
                end else begin
                    dq_head = dq_head - 8'd1;
                    dq_mem[dq_head] = word;
                    dq_count++;
                end
            end
            OP_DEL_FST: begin
                if (dq_count == 0) begin
                    rep.status = ST_EMPTY;
                end else begin
                    dq_head = dq_head + 8'd1;
                    dq_count--;
                end
            end
            OP_DEL_LST: begin
                if (dq_count == 0) rep.status = ST_EMPTY;
                else dq_count--;
            end
            OP_DEL_ALL: begin
                // survivors slide toward the head, order kept
                kept = '0;
                for (int r = 0; r < dq_count; r++) begin
                    e = dq_mem[ring_slot(r[7:0])];
                    if (e != word) begin
                        dq_mem[ring_slot(kept[7:0])] = e;
                        kept++;
                    end
                end
                dq_count = kept;
            end
            OP_READ: begin
                if ({1'b0, pos} >= dq_count) rep.status = ST_RANGE;
                else rep.read_data = dq_mem[ring_slot(pos)];
            end
            default: begin
            end
        endcase
        rep.count = dq_count;
        reply_q.push_back(rep);
    endtask

    // request driver: pops the next request when the slot is free, with random idle gaps
    int send_gap = 0;
    always @(posedge i_clk) begin : driver
        t_request req;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_in_valid && o_in_ready)
                apply_deque_op(i_op, i_value, i_position);
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0 && !no_idle) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (request_q.size() > 0) begin
                    req = request_q.pop_front();
                    i_op       <= req.op;
                    i_value    <= req.word;
                    i_position <= req.pos;
                    i_in_valid <= 1'b1;
                    if (!no_idle && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 10);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // reply monitor with random back-pressure bursts
    int stall_left = 0;
    always @(posedge i_clk) begin : monitor
        t_reply want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (reply_q.size() == 0) begin
                    $error("reply with no request outstanding: count %0d status %0d",
                           o_count, o_status);
                    fail_count++;
                end else begin
                    want = reply_q.pop_front();
                    if (o_read_data !== want.read_data) begin
                        $error("read_data: expected %0d, got %0d", want.read_data, o_read_data);
                        fail_count++;
                    end
                    if (o_count !== want.count) begin
                        $error("count: expected %0d, got %0d", want.count, o_count);
                        fail_count++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        fail_count++;
                    end
                end
            end
            if (stall_left > 0 && !no_idle) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 9);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // ends the run if neither channel moves for too long
    initial begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) stuck = 0;
            else stuck++;
        end
        $display("deque_with_delete_all_core verification failed");
        $finish;
    end

    task automatic send(input logic [2:0] op, input logic signed [31:0] word,
                        input logic [7:0] pos);
        t_request req;
        req.op   = op;
        req.word = word;
        req.pos  = pos;
        request_q.push_back(req);
    endtask

    function automatic logic signed [31:0] pick_word();
        if ($urandom_range(0, 99) < 85) return word_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    function automatic logic [2:0] pick_push();
        return $urandom_range(0, 1) ? OP_APPEND : OP_PREPEND;
    endfunction

    // hold off until every request went out and every reply came back
    task automatic wait_drained();
        while (request_q.size() != 0 || i_in_valid || reply_q.size() != 0)
            @(posedge i_clk);
    endtask

    // random mix, push_pct sets how often the list grows
    task automatic send_mix(input int n, input int push_pct);
        int sel;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < push_pct) begin
                send(pick_push(), pick_word(), 8'($urandom));
            end else begin
                sel = $urandom_range(0, 19);
                if (sel <= 3)
                    send(OP_READ, $urandom, 8'($urandom_range(0, 31)));
                else if (sel <= 6)
                    send(OP_READ, $urandom, 8'($urandom_range(0, 255)));
                else if (sel <= 10)
                    send(OP_DEL_FST, $urandom, 8'($urandom));
                else if (sel <= 14)
                    send(OP_DEL_LST, $urandom, 8'($urandom));
                else if (sel <= 18)
                    send(OP_DEL_ALL, pick_word(), 8'($urandom));
                else
                    send($urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B, $urandom,
                         8'($urandom));
            end
        end
    endtask

    initial begin : stimulus
        int n;
        word_pool[0] = 32'sh8000_0000;
        word_pool[1] = 32'sh7fff_ffff;
        word_pool[2] = '0;
        word_pool[3] = -32'sd1;
        for (int k = 4; k < 8; k++) word_pool[k] = $urandom;

        // directed: empty cases, extreme words, wrap of the head, compaction
        send(OP_DEL_FST, 32'sd0, 8'd0);
        send(OP_DEL_LST, 32'sd0, 8'd0);
        send(OP_DEL_ALL, 32'sd0, 8'd0);
        send(OP_READ, 32'sd0, 8'd0);
        send(OP_APPEND, 32'sh7fff_ffff, 8'hff);
        send(OP_APPEND, 32'sh8000_0000, 8'd0);
        send(OP_PREPEND, -32'sd1, 8'd0);
        send(OP_PREPEND, 32'sd0, 8'd0);
        send(OP_PREPEND, 32'sh8000_0000, 8'd0);
        send(OP_READ, 32'sd0, 8'd0);
        send(OP_READ, 32'sd0, 8'd4);
        send(OP_READ, 32'sd0, 8'd5);
        send(OP_READ, 32'sd0, 8'd255);
        send(OP_SPARE_A, $urandom, 8'($urandom));
        send(OP_SPARE_B, $urandom, 8'($urandom));
        send(OP_DEL_ALL, 32'sh5a5a_5a5a, 8'd0);
        // matches at both ends of the list
        send(OP_DEL_ALL, 32'sh8000_0000, 8'd0);
        send(OP_READ, 32'sd0, 8'd0);
        send(OP_READ, 32'sd0, 8'd2);
        send(OP_DEL_FST, 32'sd0, 8'd0);
        send(OP_DEL_LST, 32'sd0, 8'd0);
        // every entry matches
        send(OP_DEL_ALL, -32'sd1, 8'd0);
        send(OP_READ, 32'sd0, 8'd0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait_drained();
        send_mix(40, 55);
        wait_drained();

        // fill to the brim, then knock on the full list
        n = DEPTH - dq_count;
        for (int k = 0; k < n; k++) send(pick_push(), pick_word(), 8'($urandom));
        for (int k = 0; k < 3; k++) send(pick_push(), pick_word(), 8'($urandom));
        send(OP_READ, $urandom, 8'd255);
        send(OP_READ, $urandom, 8'd0);
        send(OP_READ, $urandom, 8'($urandom));
        send(OP_DEL_ALL, 32'sh1357_9bdf, 8'($urandom));
        send(OP_DEL_LST, $urandom, 8'($urandom));
        send(OP_APPEND, pick_word(), 8'($urandom));
        send(OP_DEL_FST, $urandom, 8'($urandom));
        send(OP_PREPEND, pick_word(), 8'($urandom));
        send_mix(60, 20);
        wait_drained();

        // drain: wipe each pooled word, then pop the rest past empty
        for (int k = 0; k < 8; k++) send(OP_DEL_ALL, word_pool[k], 8'($urandom));
        wait_drained();
        n = dq_count + 2;
        for (int k = 0; k < n; k++)
            send($urandom_range(0, 1) ? OP_DEL_FST : OP_DEL_LST, $urandom, 8'($urandom));
        wait_drained();

        // closing stretch at full rate
        no_idle = 1'b1;
        send_mix(50, 50);
        wait_drained();
        repeat (20) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("deque_with_delete_all_core verification clean");
        end else begin
            $display("deque_with_delete_all_core verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/dqda_pkg.sv
rtl/dqda_ram.sv
rtl/deque_with_delete_all_core.sv
rtl/dqda_checker.sv
verif/deque_with_delete_all_core_test.sv
